>>> design/edq_pkg.sv
// Shared types, codes and default sizes for the earliest-deadline-first ready queue.
package edq_pkg;

  // Default sizes handed to the top level as parameter defaults.
  localparam int QueueDepthDef = 16;
  localparam int TaskIdBitsDef = 8;

  // Fixed port widths.
  localparam int CmdW   = 2;
  localparam int StatW  = 2;
  localparam int IdW    = 8;
  localparam int TimeW  = 32;
  localparam int ActW   = 5;
  localparam int TotalW = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_RELEASE  = 2'd0,
    CMD_COMPLETE = 2'd1,
    CMD_OVERDUE  = 2'd2
  } cmd_t;

  typedef enum logic [StatW-1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WALK,
    ST_PUT,
    ST_FETCH,
    ST_REPORT
  } state_t;

endpackage

>>> design/edq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module edq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

>>> design/edf_deadline_queue.sv
// Top level of the earliest-deadline-first ready queue: sequencer, pointers and counters.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+------------------------------------
//   input   | in_cmd in_task_num in_release_time      | item taken when start=1 and busy=0
//           | in_abs_deadline in_now                  |
//   result  | out_status out_retired_* out_run_*      | item shown for one cycle while
//           | out_timer_period out_*_count            | out_valid=1, cannot be held off
//
// A complete, an overdue check, a rejected release or an undefined command steps through
// dispatch, fetch and report, and the result strobes after the report step. A release into
// a non-empty queue walks backward from the tail, one entry per cycle through the single
// queue RAM, then fetches and reports, with a put step first when every deadline was later.
// Reset clears the fill count, head pointer, totals and the sequencer; the queue RAM is not
// cleared, since only entries below the fill count are ever read. The receiver cannot stall.
module edf_deadline_queue #(
  parameter int QUEUE_DEPTH  = edq_pkg::QueueDepthDef,
  parameter int TASK_ID_BITS = edq_pkg::TaskIdBitsDef
) (
  input  logic                       clk,
  input  logic                       rst_n,

  input  logic                       start,
  output logic                       busy,
  input  logic [edq_pkg::CmdW-1:0]   in_cmd,
  input  logic [edq_pkg::IdW-1:0]    in_task_num,
  input  logic [edq_pkg::TimeW-1:0]  in_release_time,
  input  logic [edq_pkg::TimeW-1:0]  in_abs_deadline,
  input  logic [edq_pkg::TimeW-1:0]  in_now,

  output logic                       out_valid,
  output logic [edq_pkg::StatW-1:0]  out_status,
  output logic                       out_retired_valid,
  output logic                       out_retired_kind,
  output logic [edq_pkg::IdW-1:0]    out_retired_task,
  output logic [edq_pkg::TimeW-1:0]  out_retired_release,
  output logic [edq_pkg::TimeW-1:0]  out_retired_finish,
  output logic                       out_run_valid,
  output logic [edq_pkg::IdW-1:0]    out_run_task,
  output logic [edq_pkg::TimeW-1:0]  out_timer_period,
  output logic [edq_pkg::ActW-1:0]   out_active_count,
  output logic [edq_pkg::TotalW-1:0] out_complete_count,
  output logic [edq_pkg::TotalW-1:0] out_overdue_count
);

  localparam int PtrW  = $clog2(QUEUE_DEPTH);
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SumW  = PtrW + 1;
  localparam int TimeW = edq_pkg::TimeW;
  localparam int EntW  = 2 * TimeW + TASK_ID_BITS;
  localparam logic [edq_pkg::TotalW-1:0] TotalMax = '1;

  // Queue entries are stored as {deadline, release, id}. The queue is a ring: the head
  // pointer marks the earliest deadline and the entries follow it in deadline order.

  edq_pkg::state_t state_r, state_nxt;

  logic [PtrW-1:0]  head_r, head_nxt;
  logic [CntW-1:0]  fill_r, fill_nxt;
  logic [PtrW-1:0]  cur_r, cur_nxt;
  logic [CntW-1:0]  rem_r, rem_nxt;

  logic [edq_pkg::CmdW-1:0] cmd_r;
  logic [TASK_ID_BITS-1:0]  id_r;
  logic [TimeW-1:0]         rel_r;
  logic [TimeW-1:0]         dl_r;
  logic [TimeW-1:0]         now_r;

  logic [edq_pkg::TotalW-1:0] done_cnt_r, done_cnt_nxt;
  logic [edq_pkg::TotalW-1:0] late_cnt_r, late_cnt_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [edq_pkg::StatW-1:0]  status_r, status_nxt;
  logic                       ret_valid_r, ret_valid_nxt;
  logic                       ret_kind_r, ret_kind_nxt;
  logic [edq_pkg::IdW-1:0]    ret_task_r, ret_task_nxt;
  logic [TimeW-1:0]           ret_rel_r, ret_rel_nxt;
  logic [TimeW-1:0]           ret_fin_r, ret_fin_nxt;
  logic                       run_valid_r, run_valid_nxt;
  logic [edq_pkg::IdW-1:0]    run_task_r, run_task_nxt;
  logic [TimeW-1:0]           period_r, period_nxt;

  // RAM port controls.
  logic             wr_en;
  logic [PtrW-1:0]  wr_addr;
  logic [EntW-1:0]  wr_data;
  logic [PtrW-1:0]  rd_addr;
  logic [EntW-1:0]  rd_data;

  logic [TimeW-1:0]        rd_dl;
  logic [TimeW-1:0]        rd_rel;
  logic [TASK_ID_BITS-1:0] rd_id;
  logic [EntW-1:0]         new_entry;

  logic            accept;
  logic            empty_c;
  logic            full_c;
  logic            later_c;      // stored entry's deadline is later than the new one
  logic            overdue_c;    // head deadline strictly below now
  logic [PtrW-1:0] head_inc;
  logic [PtrW-1:0] cur_inc;
  logic [PtrW-1:0] cur_dec;
  logic [SumW-1:0] tail_sum;
  logic [SumW-1:0] tail_wrap;
  logic [PtrW-1:0] tail;

  assign accept    = start && (state_r == edq_pkg::ST_IDLE);
  assign busy      = (state_r != edq_pkg::ST_IDLE);

  assign rd_dl     = rd_data[EntW-1 -: TimeW];
  assign rd_rel    = rd_data[TASK_ID_BITS +: TimeW];
  assign rd_id     = rd_data[TASK_ID_BITS-1:0];
  assign new_entry = {dl_r, rel_r, id_r};

  assign empty_c   = (fill_r == '0);
  assign full_c    = (fill_r == CntW'(QUEUE_DEPTH));
  assign later_c   = (rd_dl > dl_r);
  assign overdue_c = (rd_dl < now_r);

  assign head_inc  = (head_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign cur_inc   = (cur_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : cur_r + 1'b1;
  assign cur_dec   = (cur_r == '0) ? PtrW'(QUEUE_DEPTH - 1) : cur_r - 1'b1;

  // Physical slot of the last queued entry: head plus fill minus one, wrapped once.
  assign tail_sum  = {1'b0, head_r} + SumW'(fill_r - 1'b1);
  assign tail_wrap = (tail_sum >= SumW'(QUEUE_DEPTH)) ? tail_sum - SumW'(QUEUE_DEPTH)
                                                      : tail_sum;
  assign tail      = tail_wrap[PtrW-1:0];

  edq_ram #(
    .WIDTH (EntW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      edq_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = edq_pkg::ST_DISPATCH;
        end
      end
      edq_pkg::ST_DISPATCH: begin
        // Only a release into a queue that is neither empty nor full needs the walk.
        if (cmd_r == edq_pkg::CMD_RELEASE && !empty_c && !full_c) begin
          state_nxt = edq_pkg::ST_WALK;
        end else begin
          state_nxt = edq_pkg::ST_FETCH;
        end
      end
      edq_pkg::ST_WALK: begin
        if (!later_c) begin
          state_nxt = edq_pkg::ST_FETCH;
        end else if (rem_r == CntW'(1)) begin
          state_nxt = edq_pkg::ST_PUT;
        end
      end
      edq_pkg::ST_PUT:    state_nxt = edq_pkg::ST_FETCH;
      edq_pkg::ST_FETCH:  state_nxt = edq_pkg::ST_REPORT;
      edq_pkg::ST_REPORT: state_nxt = edq_pkg::ST_IDLE;
      default:            state_nxt = edq_pkg::ST_IDLE;
    endcase
  end

  // Datapath, RAM controls and result fields.
  always_comb begin
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    cur_nxt       = cur_r;
    rem_nxt       = rem_r;
    done_cnt_nxt  = done_cnt_r;
    late_cnt_nxt  = late_cnt_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    ret_valid_nxt = ret_valid_r;
    ret_kind_nxt  = ret_kind_r;
    ret_task_nxt  = ret_task_r;
    ret_rel_nxt   = ret_rel_r;
    ret_fin_nxt   = ret_fin_r;
    run_valid_nxt = run_valid_r;
    run_task_nxt  = run_task_r;
    period_nxt    = period_r;
    wr_en         = 1'b0;
    wr_addr       = head_r;
    wr_data       = new_entry;
    rd_addr       = head_r;   // the head is read whenever nothing else needs the port

    unique case (state_r)
      edq_pkg::ST_IDLE: begin
        if (accept) begin
          status_nxt    = edq_pkg::STAT_DONE;
          ret_valid_nxt = 1'b0;
          ret_kind_nxt  = 1'b0;
          ret_task_nxt  = '0;
          ret_rel_nxt   = '0;
          ret_fin_nxt   = '0;
        end
      end

      edq_pkg::ST_DISPATCH: begin
        // rd_data holds the head entry here.
        unique case (cmd_r)
          edq_pkg::CMD_RELEASE: begin
            if (full_c) begin
              status_nxt = edq_pkg::STAT_FULL;
            end else if (empty_c) begin
              wr_en    = 1'b1;
              wr_addr  = head_r;
              fill_nxt = fill_r + 1'b1;
            end else begin
              rd_addr = tail;
              cur_nxt = tail;
              rem_nxt = fill_r;
            end
          end
          edq_pkg::CMD_COMPLETE, edq_pkg::CMD_OVERDUE: begin
            if (empty_c || (cmd_r == edq_pkg::CMD_OVERDUE && !overdue_c)) begin
              status_nxt = edq_pkg::STAT_NONE;
            end else begin
              ret_valid_nxt = 1'b1;
              ret_kind_nxt  = (cmd_r == edq_pkg::CMD_OVERDUE);
              ret_task_nxt  = edq_pkg::IdW'(rd_id);
              ret_rel_nxt   = rd_rel;
              ret_fin_nxt   = now_r;
              head_nxt      = head_inc;
              fill_nxt      = fill_r - 1'b1;
              if (cmd_r == edq_pkg::CMD_OVERDUE) begin
                if (late_cnt_r != TotalMax) begin
                  late_cnt_nxt = late_cnt_r + 1'b1;
                end
              end else if (done_cnt_r != TotalMax) begin
                done_cnt_nxt = done_cnt_r + 1'b1;
              end
            end
          end
          default: begin
            // An undefined command changes nothing and reports done.
          end
        endcase
      end

      edq_pkg::ST_WALK: begin
        // rd_data holds the entry at cur_r. A later deadline moves up one slot; otherwise
        // the new task lands just above it, which keeps equal deadlines in arrival order.
        wr_en   = 1'b1;
        wr_addr = cur_inc;
        if (later_c) begin
          wr_data = rd_data;
          if (rem_r != CntW'(1)) begin
            rd_addr = cur_dec;
            cur_nxt = cur_dec;
            rem_nxt = rem_r - 1'b1;
          end
        end else begin
          wr_data  = new_entry;
          fill_nxt = fill_r + 1'b1;
        end
      end

      edq_pkg::ST_PUT: begin
        // Every queued deadline was later: the new task becomes the head slot.
        wr_en    = 1'b1;
        wr_addr  = cur_r;
        fill_nxt = fill_r + 1'b1;
      end

      edq_pkg::ST_FETCH: begin
        rd_addr = head_r;
      end

      edq_pkg::ST_REPORT: begin
        out_valid_nxt = 1'b1;
        if (empty_c) begin
          run_valid_nxt = 1'b0;
          run_task_nxt  = '0;
          period_nxt    = '0;
        end else begin
          run_valid_nxt = 1'b1;
          run_task_nxt  = edq_pkg::IdW'(rd_id);
          period_nxt    = (rd_dl <= now_r) ? TimeW'(1) : rd_dl - now_r;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= edq_pkg::ST_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      done_cnt_r  <= '0;
      late_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      done_cnt_r  <= done_cnt_nxt;
      late_cnt_r  <= late_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      id_r  <= TASK_ID_BITS'(in_task_num);
      rel_r <= in_release_time;
      dl_r  <= in_abs_deadline;
      now_r <= in_now;
    end
    cur_r       <= cur_nxt;
    rem_r       <= rem_nxt;
    status_r    <= status_nxt;
    ret_valid_r <= ret_valid_nxt;
    ret_kind_r  <= ret_kind_nxt;
    ret_task_r  <= ret_task_nxt;
    ret_rel_r   <= ret_rel_nxt;
    ret_fin_r   <= ret_fin_nxt;
    run_valid_r <= run_valid_nxt;
    run_task_r  <= run_task_nxt;
    period_r    <= period_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_retired_valid   = ret_valid_r;
  assign out_retired_kind    = ret_kind_r;
  assign out_retired_task    = ret_task_r;
  assign out_retired_release = ret_rel_r;
  assign out_retired_finish  = ret_fin_r;
  assign out_run_valid       = run_valid_r;
  assign out_run_task        = run_task_r;
  assign out_timer_period    = period_r;
  assign out_active_count    = edq_pkg::ActW'(fill_r);
  assign out_complete_count  = done_cnt_r;
  assign out_overdue_count   = late_cnt_r;

  // The fill count never passes the queue depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CntW'(QUEUE_DEPTH))
    else $error("queue fill count exceeds depth");

  // A result strobe only follows the report step.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == edq_pkg::ST_REPORT))
    else $error("result strobe without report step");

  // The backward walk always has at least one entry left to examine.
  a_walk_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == edq_pkg::ST_WALK) |-> (rem_r != '0))
    else $error("insert walk ran past the head");

  // The running task is reported exactly when the queue is not empty.
  a_run_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_run_valid == (fill_r != '0)))
    else $error("run_valid disagrees with fill count");

  // A retirement always reports done status.
  a_ret_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_retired_valid) |-> (out_status == edq_pkg::STAT_DONE))
    else $error("retired item with non-done status");

endmodule
